// ----- rtl/lidar_scan_sector_reducer_assert.svh -----
// assertion macros for the lidar scan sector reducer
// included by the top level, no other dependencies
`ifndef LIDAR_SCAN_SECTOR_REDUCER_ASSERT_SVH
`define LIDAR_SCAN_SECTOR_REDUCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LSSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lssr check failed");

// next-cycle implication, disabled during reset
`define LSSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lssr check failed");

`endif

// ----- rtl/lssr_pkg.sv -----
// types and constants for the lidar scan sector reducer
// no dependencies
package lssr_pkg;

   localparam logic [15:0] FULL_TURN = 16'd36000;
   localparam logic [15:0] HALF_TURN = 16'd18000;
   localparam logic [11:0] COUNT_MAX = 12'd4095;

   localparam logic [15:0] RST_SECTOR_START = 16'd34500;
   localparam logic [15:0] RST_SECTOR_END   = 16'd1500;
   localparam logic [15:0] RST_TARGET_ANGLE = 16'd0;
   localparam logic [14:0] RST_ANGLE_TOL    = 15'd500;
   localparam logic [15:0] RST_MIN_RANGE    = 16'd50;
   localparam logic [15:0] RST_MAX_RANGE    = 16'd12000;
   localparam logic [15:0] RST_OBST_THRESH  = 16'd500;

   typedef enum logic [2:0] {
      CSR_SECTOR_START = 3'd0,
      CSR_SECTOR_END   = 3'd1,
      CSR_TARGET_ANGLE = 3'd2,
      CSR_ANGLE_TOL    = 3'd3,
      CSR_MIN_RANGE    = 3'd4,
      CSR_MAX_RANGE    = 3'd5,
      CSR_OBST_THRESH  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] point_angle;
      logic [15:0] point_distance;
      logic        last_point;
   } req_word_type;

   typedef struct packed {
      logic [15:0] closest_distance;
      logic        closest_found;
      logic [15:0] target_distance;
      logic        target_found;
      logic [11:0] valid_count;
      logic        obstacle;
   } rsp_word_type;

endpackage

// ----- rtl/lidar_scan_sector_reducer.sv -----
// lidar scan sector reducer: top level, reduces a scan of points to one result word
// depends on lssr_pkg and lidar_scan_sector_reducer_assert.svh
//
//   channel | direction | handshake               | word
//   req     | in        | req_valid / req_stall   | lssr_pkg::req_word_type
//   rsp     | out       | rsp_valid / rsp_stall   | lssr_pkg::rsp_word_type
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// one point per cycle unless stalled; input register, one compare/update stage,
// result register. a taken point goes through the input register into the scan
// state; a result appears the cycle after its last point is processed.
// reset restores the register defaults and clears the scan state.
// only a last point waits on a full, stalled result register; csr_ready stays high.
`include "lidar_scan_sector_reducer_assert.svh"

module lidar_scan_sector_reducer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lssr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lssr_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data
);
   import lssr_pkg::*;

   // configuration
   logic [15:0] sector_start_ff, sector_end_ff, target_angle_ff;
   logic [14:0] angle_tol_ff;
   logic [15:0] min_range_ff, max_range_ff, obst_thresh_ff;

   // input register
   req_word_type in_ff;
   logic         in_vld_ff;

   // scan state
   logic [15:0] sector_min_ff, sector_min_in;
   logic        sector_hit_ff, sector_hit_in;
   logic [14:0] best_diff_ff, best_diff_in;
   logic [15:0] best_target_ff, best_target_in;
   logic        target_hit_ff, target_hit_in;
   logic [11:0] point_count_ff, point_count_in;

   // result register
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         rsp_vld_ff, rsp_vld_in;

   logic        adv, req_take;
   logic        dist_ok, in_sector, take_sector, take_target, diff_ok;
   logic [15:0] bound, diff_raw, diff_wrap;
   logic [14:0] diff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_start_ff <= RST_SECTOR_START;
         sector_end_ff   <= RST_SECTOR_END;
         target_angle_ff <= RST_TARGET_ANGLE;
         angle_tol_ff    <= RST_ANGLE_TOL;
         min_range_ff    <= RST_MIN_RANGE;
         max_range_ff    <= RST_MAX_RANGE;
         obst_thresh_ff  <= RST_OBST_THRESH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SECTOR_START: sector_start_ff <= csr_data;
            CSR_SECTOR_END:   sector_end_ff   <= csr_data;
            CSR_TARGET_ANGLE: target_angle_ff <= csr_data;
            CSR_ANGLE_TOL:    angle_tol_ff    <= csr_data[14:0];
            CSR_MIN_RANGE:    min_range_ff    <= csr_data;
            CSR_MAX_RANGE:    max_range_ff    <= csr_data;
            CSR_OBST_THRESH:  obst_thresh_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // a last point needs room in the result register
   assign adv       = in_vld_ff && (!in_ff.last_point || !rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= req_take || (in_vld_ff && !adv);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_word;
      end
   end

   always_comb begin
      dist_ok = (in_ff.point_distance != 16'd0) && (in_ff.point_distance >= min_range_ff)
                && (in_ff.point_distance <= max_range_ff);

      // sector wraps past zero when end is below start
      if (sector_start_ff <= sector_end_ff) begin
         in_sector = (in_ff.point_angle >= sector_start_ff)
                     && (in_ff.point_angle <= sector_end_ff);
      end else begin
         in_sector = (in_ff.point_angle >= sector_start_ff)
                     || (in_ff.point_angle <= sector_end_ff);
      end
      bound       = sector_hit_ff ? sector_min_ff : max_range_ff;
      take_sector = dist_ok && in_sector && (in_ff.point_distance < bound);

      diff_raw  = (in_ff.point_angle >= target_angle_ff) ?
                  in_ff.point_angle - target_angle_ff : target_angle_ff - in_ff.point_angle;
      // angles more than a full turn from the target never match it
      diff_ok   = diff_raw <= FULL_TURN;
      diff_wrap = (diff_raw > HALF_TURN) ? FULL_TURN - diff_raw : diff_raw;
      diff      = diff_wrap[14:0];
      take_target = dist_ok && diff_ok && (diff <= angle_tol_ff)
                    && (!target_hit_ff || (diff < best_diff_ff));

      sector_min_in  = take_sector ? in_ff.point_distance : sector_min_ff;
      sector_hit_in  = sector_hit_ff || take_sector;
      best_diff_in   = take_target ? diff : best_diff_ff;
      best_target_in = take_target ? in_ff.point_distance : best_target_ff;
      target_hit_in  = target_hit_ff || take_target;
      point_count_in = (dist_ok && (point_count_ff < COUNT_MAX)) ?
                       point_count_ff + 12'd1 : point_count_ff;

      rsp_word_in.closest_distance = sector_hit_in ? sector_min_in : 16'd0;
      rsp_word_in.closest_found    = sector_hit_in;
      rsp_word_in.target_distance  = target_hit_in ? best_target_in : 16'd0;
      rsp_word_in.target_found     = target_hit_in;
      rsp_word_in.valid_count      = point_count_in;
      rsp_word_in.obstacle         = sector_hit_in && (sector_min_in < obst_thresh_ff);

      rsp_vld_in = (adv && in_ff.last_point) || (rsp_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_hit_ff  <= 1'b0;
         target_hit_ff  <= 1'b0;
         point_count_ff <= 12'd0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (adv) begin
            if (in_ff.last_point) begin
               sector_hit_ff  <= 1'b0;
               target_hit_ff  <= 1'b0;
               point_count_ff <= 12'd0;
            end else begin
               sector_hit_ff  <= sector_hit_in;
               target_hit_ff  <= target_hit_in;
               point_count_ff <= point_count_in;
            end
         end
      end
   end

   // minimum and best diff are only read while their hit flags are set
   always_ff @(posedge clock) begin
      if (adv) begin
         sector_min_ff  <= sector_min_in;
         best_diff_ff   <= best_diff_in;
         best_target_ff <= best_target_in;
      end
      if (adv && in_ff.last_point) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_word_ff;

   `LSSR_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_vld_ff)
   `LSSR_ASSERT_NOW(a_rsp_from_last, clock, reset, $rose(rsp_vld_ff), $past(adv && in_ff.last_point))
   `LSSR_ASSERT_NEXT(a_clear_after_last, clock, reset, adv && in_ff.last_point, !sector_hit_ff && !target_hit_ff && (point_count_ff == 12'd0))
   `LSSR_ASSERT_NOW(a_obstacle_in_sector, clock, reset, rsp_vld_ff && rsp_word_ff.obstacle, rsp_word_ff.closest_found)

endmodule
